// ===== rtl/kct_pkg.sv =====
package kct_pkg;

    localparam int TOP_ROWS_DEF  = 11;
    localparam int MAX_SEQS_DEF  = 4096;
    localparam int SLOT_BITS_DEF = 26;

    localparam int CNT_W = 12;
    localparam logic [CNT_W-1:0] SEQ_COUNT_RST = 12'd4095;
    localparam logic [CNT_W-1:0] CNT_TOP       = 12'd4095;

    typedef enum logic [1:0] {
        KIND_TOP     = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_BUCKET  = 2'd2
    } kind_t;

    // control shared by every cell of the ranking chain
    typedef struct packed {
        logic ins;
        logic shift;
    } chain_ctrl_t;

endpackage

// ===== rtl/kct_cell.sv =====
module kct_cell
    import kct_pkg::*;
#(
    parameter int SW = SLOT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  chain_ctrl_t      ctrl,
    input  logic [CNT_W-1:0] new_cnt,
    input  logic [SW-1:0]    new_slot,
    input  logic             prev_valid,
    input  logic [CNT_W-1:0] prev_cnt,
    input  logic [SW-1:0]    prev_slot,
    input  logic             prev_beats,
    input  logic             next_valid,
    input  logic [CNT_W-1:0] next_cnt,
    input  logic [SW-1:0]    next_slot,
    output logic             valid,
    output logic [CNT_W-1:0] cnt,
    output logic [SW-1:0]    slot,
    output logic             beats
);

    logic             valid_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SW-1:0]    slot_reg;

    // new entry ranks ahead of this cell: cell empty, higher count, or equal count and lower slot
    assign beats = !valid_reg || (new_cnt > cnt_reg)
                   || ((new_cnt == cnt_reg) && (new_slot < slot_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= next_valid;
        end
        else if (ctrl.ins && beats)
        begin
            valid_reg <= prev_beats ? prev_valid : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            cnt_reg  <= next_cnt;
            slot_reg <= next_slot;
        end
        else if (ctrl.ins && beats)
        begin
            // take the neighbour's entry when it is pushed down, else the new one
            cnt_reg  <= prev_beats ? prev_cnt  : new_cnt;
            slot_reg <= prev_beats ? prev_slot : new_slot;
        end
    end

    assign valid = valid_reg;
    assign cnt   = cnt_reg;
    assign slot  = slot_reg;

endmodule

// ===== rtl/kct_topk.sv =====
module kct_topk
    import kct_pkg::*;
#(
    parameter int ROWS = TOP_ROWS_DEF,
    parameter int SW   = SLOT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  chain_ctrl_t      ctrl,
    input  logic [CNT_W-1:0] new_cnt,
    input  logic [SW-1:0]    new_slot,
    output logic             head_valid,
    output logic [CNT_W-1:0] head_cnt,
    output logic [SW-1:0]    head_slot
);

    logic             c_valid [ROWS+1];
    logic [CNT_W-1:0] c_cnt   [ROWS+1];
    logic [SW-1:0]    c_slot  [ROWS+1];
    logic             c_beats [ROWS+1];

    // tail feeds an empty entry in on shift-out; head sees no beaten predecessor
    assign c_valid[ROWS] = 1'b0;
    assign c_cnt[ROWS]   = '0;
    assign c_slot[ROWS]  = '0;
    assign c_beats[ROWS] = 1'b0;

    for (genvar i = 0; i < ROWS; i++)
    begin : g_cell
        logic             pv;
        logic [CNT_W-1:0] pc;
        logic [SW-1:0]    ps;
        logic             pb;

        if (i == 0)
        begin : g_head
            assign pv = 1'b0;
            assign pc = '0;
            assign ps = '0;
            assign pb = 1'b0;
        end
        else
        begin : g_body
            assign pv = c_valid[i-1];
            assign pc = c_cnt[i-1];
            assign ps = c_slot[i-1];
            assign pb = c_beats[i-1];
        end

        kct_cell #(.SW(SW)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_cnt    (new_cnt),
            .new_slot   (new_slot),
            .prev_valid (pv),
            .prev_cnt   (pc),
            .prev_slot  (ps),
            .prev_beats (pb),
            .next_valid (c_valid[i+1]),
            .next_cnt   (c_cnt[i+1]),
            .next_slot  (c_slot[i+1]),
            .valid      (c_valid[i]),
            .cnt        (c_cnt[i]),
            .slot       (c_slot[i]),
            .beats      (c_beats[i])
        );
    end

    assign head_valid = c_valid[0];
    assign head_cnt   = c_cnt[0];
    assign head_slot  = c_slot[0];

endmodule

// ===== rtl/kmer_count_top_k_histogram_stats_core.sv =====
// Slot requests: each takes a histogram read, then write-back of the increment; s_tready is
// low during a write-back. Report after the last request: the top rows, a median scan of the
// histogram, the summary row, then a bucket scan over every count value that also clears the
// histogram; output stalls hold the top rows, the summary and the bucket scan.
// Reset: asynchronous, active low; then a clearing scan of all counts, s_tready held low.
module kmer_count_top_k_histogram_stats_core
    import kct_pkg::*;
#(
    parameter int TOP_ROWS  = TOP_ROWS_DEF,
    parameter int MAX_SEQS  = MAX_SEQS_DEF,
    parameter int SLOT_BITS = SLOT_BITS_DEF,
    localparam int DATA_W   = 3 * SLOT_BITS + 61,
    localparam int TDATA_W  = ((DATA_W + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    // register write
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,   // seq_count
    // slot requests
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,     // slot_count[11:0], zero pad
    input  logic               s_tlast,     // last
    // report rows
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,     // kmer, count, median, bucket_lo, bucket_hi,
                                            // slots, total, zero pad
    output logic [1:0]         m_tuser,     // kind
    output logic               m_tlast      // final_res
);

    localparam int HIST_DEPTH = (MAX_SEQS < 4096) ? MAX_SEQS : 4096;
    localparam int HAW        = $clog2(HIST_DEPTH);
    localparam int SCW        = SLOT_BITS + 1;
    localparam int TW         = SLOT_BITS + 12;
    localparam logic [CNT_W-1:0] CNT_CAP = (MAX_SEQS > 4096) ? CNT_TOP : CNT_W'(MAX_SEQS - 1);
    localparam logic [CNT_W-1:0] MED_END = CNT_W'(HIST_DEPTH - 1);

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_ACC   = 5'b00010,
        ST_TOP   = 5'b00100,
        ST_MED   = 5'b01000,
        ST_SUM   = 5'b10000
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  seq_count_reg;

    // histogram memory: one read port with registered data, one write port
    logic [SCW-1:0]    hist_mem [HIST_DEPTH];
    logic [SCW-1:0]    rd_data_reg;
    logic              mem_re, mem_we;
    logic [HAW-1:0]    mem_raddr, mem_waddr;
    logic [SCW-1:0]    mem_wdata;

    // accumulation
    logic              upd_pend_reg, last_pend_reg;
    logic [HAW-1:0]    upd_addr_reg;
    logic [SCW-1:0]    slot_ctr_reg;
    logic [TW:0]       sum_reg;
    logic [CNT_W-1:0]  max_cnt_reg;
    logic [SLOT_BITS-1:0] max_slot_reg;

    // scans
    logic [CNT_W-1:0]  v_reg;
    logic              phase_reg;
    logic [SCW-1:0]    seen_reg;
    logic [CNT_W-1:0]  med_a_reg, med_b_reg;
    logic              fa_reg, fb_reg;
    logic              bkt_on_reg;
    logic [CNT_W-1:0]  lo_reg, hi_reg;
    logic [SCW-1:0]    bslots_reg;
    logic [TW-1:0]     btotal_reg;

    // output register
    logic              m_valid_reg;
    kind_t             o_kind_reg;
    logic [SLOT_BITS-1:0] o_kmer_reg;
    logic [CNT_W-1:0]  o_cnt_reg, o_med_reg, o_lo_reg, o_hi_reg;
    logic [SCW-1:0]    o_slots_reg;
    logic [TW-1:0]     o_total_reg;
    logic              o_last_reg;

    logic              out_free, acc, cap_ok, in_mem, emit_need, stall;
    logic [CNT_W-1:0]  in_cnt, cl_a, cl;
    logic              head_valid;
    logic [CNT_W-1:0]  head_cnt;
    logic [SLOT_BITS-1:0] head_slot;
    chain_ctrl_t       chain_ctrl;
    logic [SCW-1:0]    h, seen_next, half, half1, acc_slots;
    logic [TW-1:0]     acc_total;
    logic [CNT_W:0]    lo_next, hi_dbl;
    logic [CNT_W-1:0]  hi_next, med_val;
    logic              bkt_end;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_ACC) && !upd_pend_reg;
    assign acc      = s_tvalid && s_tready;
    assign cap_ok   = !slot_ctr_reg[SLOT_BITS];

    // clamp to the register and to the histogram depth
    assign in_cnt = s_tdata[CNT_W-1:0];
    assign cl_a   = (in_cnt > seq_count_reg) ? seq_count_reg : in_cnt;
    assign cl     = (cl_a > CNT_CAP) ? CNT_CAP : cl_a;

    assign chain_ctrl.ins   = acc && cap_ok;
    assign chain_ctrl.shift = (state_reg == ST_TOP) && head_valid && out_free;

    kct_topk #(.ROWS(TOP_ROWS), .SW(SLOT_BITS)) u_topk (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (chain_ctrl),
        .new_cnt    (cl),
        .new_slot   (slot_ctr_reg[SLOT_BITS-1:0]),
        .head_valid (head_valid),
        .head_cnt   (head_cnt),
        .head_slot  (head_slot)
    );

    // scan datapath
    assign in_mem    = ({1'b0, v_reg} < (CNT_W+1)'(HIST_DEPTH));
    assign h         = in_mem ? rd_data_reg : '0;
    assign seen_next = seen_reg + rd_data_reg;
    assign half      = slot_ctr_reg >> 1;
    assign half1     = half + SCW'(1);
    assign acc_slots = bslots_reg + h;
    assign acc_total = btotal_reg + (TW'(v_reg) * TW'(h));
    assign lo_next   = {1'b0, hi_reg} + (CNT_W+1)'(1);
    assign hi_dbl    = (hi_reg == '0) ? (CNT_W+1)'(1) : {hi_reg, 1'b0};
    assign hi_next   = (hi_dbl > {1'b0, seq_count_reg}) ? seq_count_reg : hi_dbl[CNT_W-1:0];
    assign bkt_end   = (lo_next >= {1'b0, seq_count_reg});
    assign emit_need = bkt_on_reg && (v_reg == hi_reg);
    assign stall     = emit_need && !out_free;
    assign med_val   = CNT_W'(({1'b0, med_a_reg} + {1'b0, med_b_reg}) >> 1);

    // memory port selection
    always_comb
    begin
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = v_reg[HAW-1:0];
        mem_waddr = v_reg[HAW-1:0];
        mem_wdata = '0;
        priority case (1'b1)
            (state_reg == ST_ACC):
            begin
                mem_re    = acc && cap_ok;
                mem_raddr = cl[HAW-1:0];
                mem_we    = upd_pend_reg;
                mem_waddr = upd_addr_reg;
                mem_wdata = rd_data_reg + SCW'(1);
            end
            (state_reg == ST_MED):
            begin
                mem_re = !phase_reg;
            end
            (state_reg == ST_SWEEP):
            begin
                mem_re = !phase_reg;
                // clear each cell as it is consumed
                mem_we = phase_reg && !stall && in_mem;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= hist_mem[mem_raddr];
        end
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
    end

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_count_reg <= SEQ_COUNT_RST;
        end
        else if (cfg_we)
        begin
            seq_count_reg <= cfg_wdata;
        end
    end

    // sequencer and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            upd_pend_reg  <= 1'b0;
            last_pend_reg <= 1'b0;
            upd_addr_reg  <= '0;
            slot_ctr_reg  <= '0;
            sum_reg       <= '0;
            max_cnt_reg   <= '0;
            max_slot_reg  <= '0;
            v_reg         <= '0;
            phase_reg     <= 1'b0;
            seen_reg      <= '0;
            med_a_reg     <= '0;
            med_b_reg     <= '0;
            fa_reg        <= 1'b0;
            fb_reg        <= 1'b0;
            bkt_on_reg    <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            bslots_reg    <= '0;
            btotal_reg    <= '0;
            m_valid_reg   <= 1'b0;
            o_kind_reg    <= KIND_TOP;
            o_kmer_reg    <= '0;
            o_cnt_reg     <= '0;
            o_med_reg     <= '0;
            o_lo_reg      <= '0;
            o_hi_reg      <= '0;
            o_slots_reg   <= '0;
            o_total_reg   <= '0;
            o_last_reg    <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_ACC:
                begin
                    if (upd_pend_reg)
                    begin
                        upd_pend_reg <= 1'b0;
                        if (last_pend_reg)
                        begin
                            state_reg <= ST_TOP;
                        end
                    end
                    else if (acc)
                    begin
                        upd_pend_reg  <= cap_ok;
                        last_pend_reg <= s_tlast;
                        if (cap_ok)
                        begin
                            upd_addr_reg <= cl[HAW-1:0];
                            sum_reg      <= sum_reg + (TW+1)'(cl);
                            slot_ctr_reg <= slot_ctr_reg + SCW'(1);
                            if (cl > max_cnt_reg)
                            begin
                                max_cnt_reg  <= cl;
                                max_slot_reg <= slot_ctr_reg[SLOT_BITS-1:0];
                            end
                        end
                        else if (s_tlast)
                        begin
                            state_reg <= ST_TOP;
                        end
                    end
                end
                ST_TOP:
                begin
                    if (!head_valid)
                    begin
                        state_reg <= ST_MED;
                        v_reg     <= '0;
                        phase_reg <= 1'b0;
                        seen_reg  <= '0;
                        fa_reg    <= 1'b0;
                        fb_reg    <= 1'b0;
                        med_a_reg <= '0;
                        med_b_reg <= '0;
                    end
                    else if (out_free)
                    begin
                        // drain the chain head, rank order
                        m_valid_reg <= 1'b1;
                        o_kind_reg  <= KIND_TOP;
                        o_kmer_reg  <= head_slot;
                        o_cnt_reg   <= head_cnt;
                        o_med_reg   <= '0;
                        o_lo_reg    <= '0;
                        o_hi_reg    <= '0;
                        o_slots_reg <= '0;
                        o_total_reg <= '0;
                        o_last_reg  <= 1'b0;
                    end
                end
                ST_MED:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        seen_reg <= seen_next;
                        if (!fa_reg && (seen_next >= half))
                        begin
                            fa_reg    <= 1'b1;
                            med_a_reg <= v_reg;
                        end
                        if (!fb_reg && (seen_next >= half1))
                        begin
                            fb_reg    <= 1'b1;
                            med_b_reg <= v_reg;
                        end
                        if (v_reg == MED_END)
                        begin
                            state_reg <= ST_SUM;
                        end
                        else
                        begin
                            v_reg <= v_reg + CNT_W'(1);
                        end
                    end
                end
                ST_SUM:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        o_kind_reg   <= KIND_SUMMARY;
                        o_kmer_reg   <= max_slot_reg;
                        o_cnt_reg    <= max_cnt_reg;
                        o_med_reg    <= med_val;
                        o_lo_reg     <= '0;
                        o_hi_reg     <= '0;
                        o_slots_reg  <= slot_ctr_reg;
                        o_total_reg  <= sum_reg[TW-1:0];
                        o_last_reg   <= (seq_count_reg == '0);
                        // drop the set totals, the sweep clears the histogram
                        slot_ctr_reg <= '0;
                        sum_reg      <= '0;
                        max_cnt_reg  <= '0;
                        max_slot_reg <= '0;
                        state_reg    <= ST_SWEEP;
                        v_reg        <= '0;
                        phase_reg    <= 1'b0;
                        bkt_on_reg   <= (seq_count_reg != '0);
                        lo_reg       <= '0;
                        hi_reg       <= '0;
                        bslots_reg   <= '0;
                        btotal_reg   <= '0;
                    end
                end
                ST_SWEEP:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else if (!stall)
                    begin
                        phase_reg <= 1'b0;
                        if (emit_need)
                        begin
                            m_valid_reg <= 1'b1;
                            o_kind_reg  <= KIND_BUCKET;
                            o_kmer_reg  <= '0;
                            o_cnt_reg   <= '0;
                            o_med_reg   <= '0;
                            o_lo_reg    <= lo_reg;
                            o_hi_reg    <= hi_reg;
                            o_slots_reg <= acc_slots;
                            o_total_reg <= acc_total;
                            o_last_reg  <= bkt_end;
                            bslots_reg  <= '0;
                            btotal_reg  <= '0;
                            lo_reg      <= lo_next[CNT_W-1:0];
                            hi_reg      <= hi_next;
                            bkt_on_reg  <= !bkt_end;
                        end
                        else if (bkt_on_reg)
                        begin
                            bslots_reg <= acc_slots;
                            btotal_reg <= acc_total;
                        end
                        if (v_reg == CNT_TOP)
                        begin
                            state_reg <= ST_ACC;
                        end
                        else
                        begin
                            v_reg <= v_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_SWEEP;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = TDATA_W'({o_total_reg, o_slots_reg, o_hi_reg, o_lo_reg,
                                o_med_reg, o_cnt_reg, o_kmer_reg});

endmodule

// ===== rtl/kct_checker.sv =====
module kct_checker
    import kct_pkg::*;
#(
    parameter int SLOT_BITS = SLOT_BITS_DEF,
    parameter int TDATA_W   = 144
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser,
    input logic               m_tlast
);

    localparam int CB = SLOT_BITS;
    localparam int MB = SLOT_BITS + 12;
    localparam int LB = SLOT_BITS + 24;
    localparam int HB = SLOT_BITS + 36;

    // a stalled row holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled row changed");

    // the report never ends on a top row
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tuser != KIND_TOP))
        else $error("report ended on a top row");

    // median cannot exceed the maximum count
    a_med: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_SUMMARY) |-> (m_tdata[MB+11:MB] <= m_tdata[CB+11:CB]))
        else $error("median above maximum");

    // bucket bounds ordered
    a_bkt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_BUCKET) |-> (m_tdata[LB+11:LB] <= m_tdata[HB+11:HB]))
        else $error("bucket bounds reversed");

    // no request is accepted while the previous one's increment is written back
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted during write-back");

endmodule

bind kmer_count_top_k_histogram_stats_core kct_checker #(
    .SLOT_BITS (SLOT_BITS),
    .TDATA_W   (TDATA_W)
) u_kct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== dv/kct_report_checker.sv =====
`timescale 1ns / 1ps

module kct_report_checker
    import kct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [11:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [15:0]  s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    output int           errors,
    output int           pending
);

    localparam int RANKS = 11;
    localparam int DEPTH = 4096;

    typedef struct packed {
        kind_t       kind;
        logic [25:0] kmer;
        logic [11:0] cnt;
        logic [11:0] med;
        logic [11:0] lo;
        logic [11:0] hi;
        logic [26:0] slots;
        logic [37:0] total;
        logic        fin;
    } report_row_t;

    report_row_t  report_rows[$];
    logic [11:0]  seq_limit;
    int unsigned  hist[DEPTH];
    logic [25:0]  rank_slot[RANKS];
    logic [11:0]  rank_cnt[RANKS];
    int           rank_fill;
    logic [11:0]  peak_cnt;
    logic [25:0]  peak_slot;
    logic [26:0]  slot_no;
    logic [38:0]  cnt_sum;

    function automatic report_row_t blank_row(kind_t k);
        report_row_t r;
        r.kind = k; r.kmer = '0; r.cnt = '0; r.med = '0; r.lo = '0; r.hi = '0;
        r.slots = '0; r.total = '0; r.fin = 1'b0;
        return r;
    endfunction

    function automatic logic [11:0] rank_value(longint unsigned rank);
        longint unsigned seen;
        seen = 0;
        for (int c = 0; c < DEPTH; c++)
        begin
            seen += hist[c];
            if (seen >= rank)
                return c[11:0];
        end
        return '0;
    endfunction

    task automatic clear_set();
        for (int c = 0; c < DEPTH; c++)
            hist[c] = 0;
        for (int i = 0; i < RANKS; i++)
        begin
            rank_slot[i] = '0;
            rank_cnt[i]  = '0;
        end
        rank_fill = 0;
        peak_cnt  = '0;
        peak_slot = '0;
        slot_no   = '0;
        cnt_sum   = '0;
    endtask

    task automatic rank_insert(logic [25:0] slot, logic [11:0] c);
        int pos;
        int i;
        pos = 0;
        if (rank_fill >= RANKS && c <= rank_cnt[RANKS-1])
            return;
        while (pos < rank_fill)
        begin
            if (c > rank_cnt[pos] || (c == rank_cnt[pos] && slot < rank_slot[pos]))
                break;
            pos++;
        end
        if (pos >= RANKS)
            return;
        i = (rank_fill < RANKS) ? rank_fill : RANKS - 1;
        while (i > pos)
        begin
            rank_slot[i] = rank_slot[i-1];
            rank_cnt[i]  = rank_cnt[i-1];
            i--;
        end
        rank_slot[pos] = slot;
        rank_cnt[pos]  = c;
        if (rank_fill < RANKS)
            rank_fill++;
    endtask

    task automatic build_report();
        report_row_t r;
        longint unsigned half;
        int lo, hi, x;
        longint unsigned n, t;
        for (int i = 0; i < rank_fill; i++)
        begin
            r = blank_row(KIND_TOP);
            r.kmer = rank_slot[i];
            r.cnt  = rank_cnt[i];
            report_rows.push_back(r);
        end
        half = slot_no / 2;
        r = blank_row(KIND_SUMMARY);
        r.kmer  = peak_slot;
        r.cnt   = peak_cnt;
        r.med   = 12'(({1'b0, rank_value(half)} + {1'b0, rank_value(half + 1)}) >> 1);
        r.slots = slot_no;
        r.total = cnt_sum[37:0];
        report_rows.push_back(r);
        lo = 0; hi = 0; x = 0;
        while (lo < seq_limit)
        begin
            n = 0; t = 0;
            for (int v = x; v <= hi && v < DEPTH; v++)
            begin
                n += hist[v];
                t += longint'(v) * hist[v];
            end
            x = hi + 1;
            r = blank_row(KIND_BUCKET);
            r.lo = lo[11:0]; r.hi = hi[11:0]; r.slots = n[26:0]; r.total = t[37:0];
            report_rows.push_back(r);
            lo = hi + 1;
            hi = (hi > 0) ? hi * 2 : 1;
            if (hi > seq_limit)
                hi = seq_limit;
        end
        report_rows[$].fin = 1'b1;
        clear_set();
    endtask

    task automatic absorb_count(logic [11:0] c, logic lst);
        if (slot_no < 27'd67108864)
        begin
            if (c > seq_limit)
                c = seq_limit;
            hist[c]++;
            cnt_sum += c;
            if (c > peak_cnt)
            begin
                peak_cnt  = c;
                peak_slot = slot_no[25:0];
            end
            rank_insert(slot_no[25:0], c);
            slot_no++;
        end
        if (lst)
            build_report();
    endtask

    task automatic check_row();
        report_row_t e;
        report_row_t a;
        a.kind  = kind_t'(m_tuser);
        a.kmer  = m_tdata[25:0];
        a.cnt   = m_tdata[37:26];
        a.med   = m_tdata[49:38];
        a.lo    = m_tdata[61:50];
        a.hi    = m_tdata[73:62];
        a.slots = m_tdata[100:74];
        a.total = m_tdata[138:101];
        a.fin   = m_tlast;
        if (report_rows.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected row: kind %0d kmer %0d cnt %0d", a.kind, a.kmer, a.cnt);
            return;
        end
        e = report_rows.pop_front();
        if (a != e)
        begin
            errors++;
            if (errors <= 10)
                $display("row mismatch: exp %p / got %p", e, a);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_limit = 12'd4095;
            errors    = 0;
            report_rows.delete();
            clear_set();
        end
        else
        begin
            if (cfg_we)
                seq_limit = cfg_wdata;
            if (s_tvalid && s_tready)
                absorb_count(s_tdata[11:0], s_tlast);
            if (m_tvalid && m_tready)
                check_row();
        end
        pending = report_rows.size();
    end

endmodule

// ===== dv/tb_kmer_count_top_k_histogram_stats_core.sv =====
`timescale 1ns / 1ps

module tb_kmer_count_top_k_histogram_stats_core;
    import kct_pkg::*;

    // longest stretch without any handshake: clearing pass, median scan and bucket scan
    // all fit well inside this
    localparam int QUIET_LIMIT = 60000;
    // settle time before a register write: the bucket scan may still be clearing
    localparam int SETTLE = 9000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [11:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    int errors;
    int pending;
    int idle_mode = 0;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
    int requests_sent = 0;
    int quiet = 0;

    always #2 clk = ~clk;

    kmer_count_top_k_histogram_stats_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    kct_report_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .errors    (errors),
        .pending   (pending)
    );

    // Stall the report side according to the current idling phase.
    always @(posedge clk)
    begin
        case (idle_mode)
            2:       m_tready <= ($urandom_range(0, 99) >= 72);
            3:       m_tready <= ($urandom_range(0, 99) >= 14);
            default: m_tready <= 1'b1;
        endcase
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("tb_kmer_count_top_k_histogram_stats_core NOT OK");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Present one slot request and hold it until it is taken; leave tvalid high so that
    // back-to-back requests need no gap. Sample tready mid-cycle, then take the edge.
    task automatic send_request(logic [11:0] c, logic lst);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 72 : (idle_mode == 3) ? 14 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, c};
        s_tlast  <= lst;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        requests_sent++;
    endtask

    // Drop tvalid and wait for the whole report to drain.
    task automatic drain_report();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_set(logic [11:0] counts[$]);
        foreach (counts[i])
            send_request(counts[i], i == counts.size() - 1);
        drain_report();
    endtask

    task automatic write_seq_count(logic [11:0] v);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random set: small counts (dense buckets), full-range counts, extremes and repeats (ties) in equal shares.
    task automatic random_set();
        logic [11:0] counts[$];
        logic [11:0] c;
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 30) : $urandom_range(1, 16);
        c = '0;
        repeat (len)
        begin
            case ($urandom_range(0, 3))
                0: c = 12'($urandom_range(0, 15));
                1: c = 12'($urandom_range(0, 4095));
                2: c = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
                default: ;  // repeat previous count: tie
            endcase
            counts.push_back(c);
        end
        send_set(counts);
    endtask

    initial
    begin
        logic [11:0] limits[$];
        int set_no;
        limits = '{12'd0, 12'd1, 12'd2, 12'd4095, 12'd100, 12'd7, 12'($urandom_range(3, 4094))};
        set_no = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: lone zero, lone maximum, overfilled ranking with ties, near-top pair with a small tail.
        send_set('{12'd0});
        send_set('{12'd4095});
        send_set('{12'd5, 12'd5, 12'd5, 12'd9, 12'd1, 12'd4095, 12'd5, 12'd3, 12'd3,
                   12'd2048, 12'd5, 12'd5, 12'd7, 12'd0});
        send_set('{12'd4095, 12'd4094, 12'd1, 12'd2});

        // Random phases, the first each under its own seq_count, the rest under the last; clamping shows up below 4095.
        foreach (limits[p])
        begin
            write_seq_count(limits[p]);
            idle_mode = set_no % 4;
            set_no++;
            random_set();
        end
        while (requests_sent < 125)
        begin
            idle_mode = set_no % 4;
            set_no++;
            random_set();
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb_kmer_count_top_k_histogram_stats_core OK");
        else
            $display("tb_kmer_count_top_k_histogram_stats_core NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kct_pkg.sv
rtl/kct_cell.sv
rtl/kct_topk.sv
rtl/kmer_count_top_k_histogram_stats_core.sv
rtl/kct_checker.sv
dv/kct_report_checker.sv
dv/tb_kmer_count_top_k_histogram_stats_core.sv
